/* design/glr_pkg.sv */
package glr_pkg;

	localparam int COORD_W    = 6;
	localparam int GRID_SIZE  = 64;
	localparam int ERR_W      = 8;
	localparam int CNT_W      = $clog2(GRID_SIZE + 1);
	localparam int DESC_DEPTH = 2;
	localparam int DPTR_W     = $clog2(DESC_DEPTH);
	localparam int DCNT_W     = $clog2(DESC_DEPTH + 1);

	typedef struct packed {
		logic [COORD_W-1:0] start_x;
		logic [COORD_W-1:0] start_y;
		logic [COORD_W-1:0] end_x;
		logic [COORD_W-1:0] end_y;
	} seg_t;

	typedef struct packed {
		logic [COORD_W-1:0] cell_x;
		logic [COORD_W-1:0] cell_y;
		logic               last_cell;
	} cell_t;

	// Segment setup handed from the classifier to the stepper.
	typedef struct packed {
		logic [COORD_W-1:0]      major_pos;
		logic [COORD_W-1:0]      minor_pos;
		logic signed [ERR_W-1:0] error_term;
		logic [COORD_W-1:0]      dmaj;
		logic [COORD_W-1:0]      dmin;
		logic                    minor_dir_neg;
		logic                    axes_swapped;
	} desc_t;

	function automatic logic [COORD_W-1:0] clamp_coord(input logic [COORD_W-1:0] v);
		logic [COORD_W-1:0] c;
		c = v;
		if (32'(v) > GRID_SIZE - 1)
			c = COORD_W'(GRID_SIZE - 1);
		return c;
	endfunction

endpackage

/* design/grid_line_rasterizer.sv */
// Path: classifier register, descriptor queue, stepper, result register. One cell per
// cycle while the result is empty or popped; a segment yields (major-axis extent + 1)
// cells, 1 to 64, set by the single stepper; the next segment loads on its last cell.
// Reset (arst_n low, asynchronous): stepper idle, descriptor queue and
// result register empty; no clearing pass.
module grid_line_rasterizer (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  glr_pkg::seg_t  segment,
	output logic           empty,
	input  logic           pop,
	output glr_pkg::cell_t result
);

	// Front to queue: classified segment setup.
	logic           fr_valid, fr_ready;
	glr_pkg::desc_t fr_desc;

	// Queue to back: setup waiting for the stepper.
	logic           q_valid, q_take;
	glr_pkg::desc_t q_desc;

	// Clamp, order endpoints by x, pick the major axis and seed the error term.
	glr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.segment    (segment),
		.desc_valid (fr_valid),
		.desc_ready (fr_ready),
		.desc       (fr_desc)
	);

	// Hold up to two setups so the classifier keeps taking segments while
	// the stepper is still walking a long one.
	glr_desc_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (fr_valid),
		.wr_ready (fr_ready),
		.wr_data  (fr_desc),
		.rd_valid (q_valid),
		.rd_take  (q_take),
		.rd_data  (q_desc)
	);

	// Advance one cell per transfer on the result side; the output register
	// parts the stepper from the consumer.
	glr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.desc_valid (q_valid),
		.desc_take  (q_take),
		.desc       (q_desc),
		.empty      (empty),
		.pop        (pop),
		.result     (result)
	);

endmodule

/* design/glr_front.sv */
module glr_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  glr_pkg::seg_t segment,
	output logic          desc_valid,
	input  logic          desc_ready,
	output glr_pkg::desc_t desc
);

	logic [glr_pkg::COORD_W-1:0] x0, y0, x1, y1;
	logic [glr_pkg::COORD_W-1:0] ax, ay, bx, by;
	logic [glr_pkg::COORD_W-1:0] dx, dy;
	logic                        dir_neg, swapped;
	glr_pkg::desc_t              desc_d;
	glr_pkg::desc_t              desc_s1;
	logic                        valid_s1;
	logic                        take;

	always_comb begin
		x0 = glr_pkg::clamp_coord(segment.start_x);
		y0 = glr_pkg::clamp_coord(segment.start_y);
		x1 = glr_pkg::clamp_coord(segment.end_x);
		y1 = glr_pkg::clamp_coord(segment.end_y);
		// order endpoints by x; equal x keeps the first endpoint first
		if (x0 > x1) begin
			ax = x1; ay = y1; bx = x0; by = y0;
		end else begin
			ax = x0; ay = y0; bx = x1; by = y1;
		end
		dx      = bx - ax;
		dir_neg = (by < ay);
		dy      = dir_neg ? (ay - by) : (by - ay);
		swapped = (dy > dx);

		desc_d.minor_dir_neg = dir_neg;
		desc_d.axes_swapped  = swapped;
		if (swapped) begin
			desc_d.major_pos = ay;
			desc_d.minor_pos = ax;
			desc_d.dmaj      = dy;
			desc_d.dmin      = dx;
		end else begin
			desc_d.major_pos = ax;
			desc_d.minor_pos = ay;
			desc_d.dmaj      = dx;
			desc_d.dmin      = dy;
		end
		desc_d.error_term = $signed({1'b0, desc_d.dmin, 1'b0})
			- $signed({2'b00, desc_d.dmaj});
	end

	assign full       = valid_s1 && !desc_ready;
	assign take       = push && !full;
	assign desc_valid = valid_s1;
	assign desc       = desc_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= take || (valid_s1 && !desc_ready);
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			desc_s1 <= desc_d;
		end
	end

endmodule

/* design/glr_desc_fifo.sv */
module glr_desc_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_valid,
	output logic           wr_ready,
	input  glr_pkg::desc_t wr_data,
	output logic           rd_valid,
	input  logic           rd_take,
	output glr_pkg::desc_t rd_data
);

	glr_pkg::desc_t              mem_q [glr_pkg::DESC_DEPTH];
	logic [glr_pkg::DPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [glr_pkg::DCNT_W-1:0]  count_q;
	logic                        wr_en, rd_en;

	assign wr_ready = (count_q != glr_pkg::DCNT_W'(glr_pkg::DESC_DEPTH));
	assign rd_valid = (count_q != '0);
	assign wr_en    = wr_valid && wr_ready;
	assign rd_en    = rd_take && rd_valid;
	assign rd_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en)
				wr_ptr_q <= (wr_ptr_q == glr_pkg::DPTR_W'(glr_pkg::DESC_DEPTH - 1))
					? '0 : wr_ptr_q + 1'b1;
			if (rd_en)
				rd_ptr_q <= (rd_ptr_q == glr_pkg::DPTR_W'(glr_pkg::DESC_DEPTH - 1))
					? '0 : rd_ptr_q + 1'b1;
			if (wr_en && !rd_en)
				count_q <= count_q + 1'b1;
			else if (rd_en && !wr_en)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

/* design/glr_back.sv */
module glr_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           desc_valid,
	output logic           desc_take,
	input  glr_pkg::desc_t desc,
	output logic           empty,
	input  logic           pop,
	output glr_pkg::cell_t result
);

	logic                            busy_q;
	logic [glr_pkg::COORD_W-1:0]     major_q, minor_q, dmaj_q, dmin_q;
	logic signed [glr_pkg::ERR_W-1:0] err_q;
	logic [glr_pkg::CNT_W-1:0]       left_q;
	logic                            dir_neg_q, swapped_q;
	logic                            out_valid_q;
	glr_pkg::cell_t                  out_q;

	logic                            emit, last, load, step_minor;
	logic                            maj_neg, min_neg;
	logic signed [glr_pkg::ERR_W:0]  err_next;

	assign last       = (left_q == glr_pkg::CNT_W'(1));
	assign emit       = busy_q && (!out_valid_q || pop);
	assign load       = desc_valid && (!busy_q || (emit && last));
	assign desc_take  = load;
	assign maj_neg    = swapped_q && dir_neg_q;
	assign min_neg    = !swapped_q && dir_neg_q;
	assign step_minor = !err_q[glr_pkg::ERR_W-1];
	assign empty      = !out_valid_q;
	assign result     = out_q;

	always_comb begin
		err_next = $signed({err_q[glr_pkg::ERR_W-1], err_q})
			+ $signed({2'b00, dmin_q, 1'b0});
		if (step_minor)
			err_next = err_next - $signed({2'b00, dmaj_q, 1'b0});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
			left_q      <= '0;
		end else begin
			if (load)
				busy_q <= 1'b1;
			else if (emit && last)
				busy_q <= 1'b0;

			if (load)
				left_q <= glr_pkg::CNT_W'(desc.dmaj) + 1'b1;
			else if (emit)
				left_q <= left_q - 1'b1;

			if (emit)
				out_valid_q <= 1'b1;
			else if (pop)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q.cell_x    <= swapped_q ? minor_q : major_q;
			out_q.cell_y    <= swapped_q ? major_q : minor_q;
			out_q.last_cell <= last;
		end
		if (load) begin
			major_q   <= desc.major_pos;
			minor_q   <= desc.minor_pos;
			err_q     <= desc.error_term;
			dmaj_q    <= desc.dmaj;
			dmin_q    <= desc.dmin;
			dir_neg_q <= desc.minor_dir_neg;
			swapped_q <= desc.axes_swapped;
		end else if (emit && !last) begin
			major_q <= maj_neg ? major_q - 1'b1 : major_q + 1'b1;
			if (step_minor)
				minor_q <= min_neg ? minor_q - 1'b1 : minor_q + 1'b1;
			err_q <= err_next[glr_pkg::ERR_W-1:0];
		end
	end

endmodule
